@@ hdl/vna_pkg.sv @@
// Shared types, codes and sizes of the vertex normal accumulator.
`default_nettype none
package vna_pkg;

   localparam int IDX_W = 10;
   localparam int VERTEX_COUNT = 1 << IDX_W;
   localparam int POS_W = 16;
   localparam int ACC_W = 48;
   localparam int NRM_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_WRITE_POS = 2'd0;
   localparam logic [1:0] CMD_ADD_TRI = 2'd1;
   localparam logic [1:0] CMD_READ_NRM = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_TRIANGLE,
      OP_READ
   } op_type;

   typedef struct packed {
      logic [1:0] command;
      logic [IDX_W-1:0] vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] read_index;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic zero_length;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic [IDX_W-1:0] vertex_index;
      logic [3*POS_W-1:0] pos;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_EDGE,
      ST_CROSS,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_NRM_RD,
      ST_NRM_CAP,
      ST_SQUARE,
      ST_SQ_DRAIN,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ hdl/vna_front.sv @@
// Front part: accepts request beats, classifies them and queues the commands.
`default_nettype none
module vna_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire vna_pkg::req_type req_data,
   output logic cmd_vld,
   input wire logic cmd_take,
   output vna_pkg::cmd_type cmd_data
);

   vna_pkg::cmd_type q_mem_ff [vna_pkg::QUEUE_DEPTH];
   logic [vna_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vna_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vna_pkg::QPTR_W:0] cnt_ff, cnt_in;
   logic enq;
   logic deq;
   logic known;
   vna_pkg::cmd_type cls;

   always_comb begin
      known = 1'b1;
      cls.op = vna_pkg::OP_WRITE;
      unique case (req_data.command)
         vna_pkg::CMD_WRITE_POS: cls.op = vna_pkg::OP_WRITE;
         vna_pkg::CMD_ADD_TRI: cls.op = vna_pkg::OP_TRIANGLE;
         vna_pkg::CMD_READ_NRM: cls.op = vna_pkg::OP_READ;
         default: known = 1'b0;
      endcase
      cls.vertex_index = req_data.vertex_index;
      cls.pos = {req_data.pos_x, req_data.pos_y, req_data.pos_z};
      cls.corner_a = req_data.corner_a;
      cls.corner_b = req_data.corner_b;
      cls.corner_c = req_data.corner_c;
   end

   assign req_full = (cnt_ff == (vna_pkg::QPTR_W+1)'(vna_pkg::QUEUE_DEPTH));
   assign cmd_vld = (cnt_ff != '0);
   assign cmd_data = q_mem_ff[rd_ptr_ff];
   assign enq = req_push && !req_full && known;
   assign deq = cmd_take && cmd_vld;

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff + (vna_pkg::QPTR_W+1)'(enq) - (vna_pkg::QPTR_W+1)'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

@@ hdl/vna_back.sv @@
// Back part: vertex memories, cross product, accumulation and normalisation.
`default_nettype none
module vna_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_vld,
   output logic cmd_take,
   input wire vna_pkg::cmd_type cmd_data,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output vna_pkg::rsp_type rsp_data
);

   localparam int PW = vna_pkg::POS_W;
   localparam int AW = vna_pkg::ACC_W;
   localparam int EW = PW + 1;
   localparam int NW = 2 * EW + 1;
   localparam int HW = AW / 2;
   localparam int SW = 2 * AW;
   localparam int RW = AW + 2;

   vna_pkg::state_type st_ff, st_in;
   vna_pkg::cmd_type cur_ff;

   logic [3*PW-1:0] pos_mem [vna_pkg::VERTEX_COUNT];
   logic [3*AW-1:0] acc_mem [vna_pkg::VERTEX_COUNT];
   logic [3*PW-1:0] pos_rd_ff;
   logic [3*AW-1:0] acc_rd_ff;
   logic [vna_pkg::IDX_W-1:0] pos_ra, acc_ra, acc_wa;
   logic pos_we, acc_we;
   logic [3*AW-1:0] acc_wd;

   logic [3*PW-1:0] pa_ff, pb_ff;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [NW-1:0] n_ff [3];
   logic [1:0] cross_cnt_ff;
   logic [1:0] corner_ff;
   logic signed [AW-1:0] vec_ff [3];
   logic [1:0] comp_ff;
   logic [1:0] part_ff;
   logic [2*HW-1:0] prod_ff;
   logic [1:0] psh_ff;
   logic prod_vld_ff;
   logic [SW-1:0] sum_ff;
   logic [RW-1:0] rem_ff;
   logic [AW-1:0] root_ff;
   logic [5:0] step_ff;
   logic [RW-1:0] r_ff;
   logic [vna_pkg::NRM_W-2:0] q_ff;
   logic [3:0] bit_ff;
   logic signed [vna_pkg::NRM_W-1:0] res_ff [3];
   logic zero_ff;
   logic rsp_vld_ff;
   vna_pkg::rsp_type rsp_ff;

   function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
      mag = v[AW-1] ? AW'(-v) : AW'(v);
   endfunction

   function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                  input logic signed [NW-1:0] d);
      logic signed [AW:0] s;
      s = {a[AW-1], a} + (AW+1)'(d);
      if (s[AW] != s[AW-1]) begin
         sat_add = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         sat_add = s[AW-1:0];
      end
   endfunction

   logic [vna_pkg::IDX_W-1:0] corner_idx;
   logic signed [EW-1:0] ma, mb, mc, md;
   logic signed [NW-1:0] cross_val;
   logic [AW-1:0] sq_mag;
   logic [HW-1:0] sq_op1, sq_op2;
   logic [SW-1:0] sum_add;
   logic [RW+1:0] rem_sh, trial;
   logic sq_ge;
   logic [RW-1:0] len_x;
   logic div_ge;
   logic [RW-1:0] div_diff;
   logic [vna_pkg::NRM_W-1:0] q_full, q_sat;
   logic signed [vna_pkg::NRM_W-1:0] q_signed;

   always_comb begin
      unique case (corner_ff)
         2'd0: corner_idx = cur_ff.corner_a;
         2'd1: corner_idx = cur_ff.corner_b;
         default: corner_idx = cur_ff.corner_c;
      endcase
      unique case (cross_cnt_ff)
         2'd0: begin ma = e1_ff[1]; mb = e2_ff[2]; mc = e1_ff[2]; md = e2_ff[1]; end
         2'd1: begin ma = e1_ff[2]; mb = e2_ff[0]; mc = e1_ff[0]; md = e2_ff[2]; end
         default: begin ma = e1_ff[0]; mb = e2_ff[1]; mc = e1_ff[1]; md = e2_ff[0]; end
      endcase
      cross_val = NW'(ma * mb) - NW'(mc * md);
      sq_mag = mag(vec_ff[comp_ff]);
      unique case (part_ff)
         2'd0: begin sq_op1 = sq_mag[HW-1:0]; sq_op2 = sq_mag[HW-1:0]; end
         2'd1: begin sq_op1 = sq_mag[AW-1:HW]; sq_op2 = sq_mag[HW-1:0]; end
         default: begin sq_op1 = sq_mag[AW-1:HW]; sq_op2 = sq_mag[AW-1:HW]; end
      endcase
      unique case (psh_ff)
         2'd0: sum_add = SW'(prod_ff);
         2'd1: sum_add = SW'(prod_ff) << (HW + 1);
         default: sum_add = SW'(prod_ff) << AW;
      endcase
      rem_sh = {rem_ff, sum_ff[SW-1:SW-2]};
      trial = {2'b00, root_ff, 2'b01};
      sq_ge = (rem_sh >= trial);
      len_x = RW'(root_ff);
      div_ge = (r_ff >= len_x);
      div_diff = div_ge ? r_ff - len_x : r_ff;
      q_full = {q_ff, div_ge};
      q_sat = q_full[vna_pkg::NRM_W-1] ? {1'b0, {(vna_pkg::NRM_W-1){1'b1}}} : q_full;
      q_signed = vec_ff[comp_ff][AW-1] ? -q_sat : q_sat;
   end

   always_comb begin
      st_in = st_ff;
      cmd_take = 1'b0;
      pos_we = 1'b0;
      acc_we = 1'b0;
      pos_ra = cur_ff.corner_a;
      acc_ra = corner_idx;
      acc_wa = corner_idx;
      acc_wd = {sat_add(acc_rd_ff[3*AW-1:2*AW], n_ff[0]),
                sat_add(acc_rd_ff[2*AW-1:AW], n_ff[1]),
                sat_add(acc_rd_ff[AW-1:0], n_ff[2])};
      unique case (st_ff)
         vna_pkg::ST_IDLE: begin
            cmd_take = 1'b1;
            if (cmd_vld) begin
               unique case (cmd_data.op)
                  vna_pkg::OP_WRITE: st_in = vna_pkg::ST_WRITE;
                  vna_pkg::OP_TRIANGLE: st_in = vna_pkg::ST_RD_A;
                  default: st_in = vna_pkg::ST_NRM_RD;
               endcase
            end
         end
         vna_pkg::ST_WRITE: begin
            pos_we = 1'b1;
            acc_we = 1'b1;
            acc_wa = cur_ff.vertex_index;
            acc_wd = '0;
            st_in = vna_pkg::ST_IDLE;
         end
         vna_pkg::ST_RD_A: st_in = vna_pkg::ST_RD_B;
         vna_pkg::ST_RD_B: begin
            pos_ra = cur_ff.corner_b;
            st_in = vna_pkg::ST_RD_C;
         end
         vna_pkg::ST_RD_C: begin
            pos_ra = cur_ff.corner_c;
            st_in = vna_pkg::ST_EDGE;
         end
         vna_pkg::ST_EDGE: st_in = vna_pkg::ST_CROSS;
         vna_pkg::ST_CROSS: begin
            if (cross_cnt_ff == 2'd2) begin
               st_in = vna_pkg::ST_ACC_RD;
            end
         end
         vna_pkg::ST_ACC_RD: st_in = vna_pkg::ST_ACC_WR;
         vna_pkg::ST_ACC_WR: begin
            acc_we = 1'b1;
            st_in = (corner_ff == 2'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_ACC_RD;
         end
         vna_pkg::ST_NRM_RD: begin
            acc_ra = cur_ff.vertex_index;
            st_in = vna_pkg::ST_NRM_CAP;
         end
         vna_pkg::ST_NRM_CAP: st_in = vna_pkg::ST_SQUARE;
         vna_pkg::ST_SQUARE: begin
            if (comp_ff == 2'd2 && part_ff == 2'd2) begin
               st_in = vna_pkg::ST_SQ_DRAIN;
            end
         end
         vna_pkg::ST_SQ_DRAIN: st_in = vna_pkg::ST_SQRT;
         vna_pkg::ST_SQRT: begin
            if (step_ff == 6'(AW - 1)) begin
               st_in = vna_pkg::ST_DIV;
            end
         end
         vna_pkg::ST_DIV: begin
            if (root_ff == '0 || (bit_ff == 4'd15 && comp_ff == 2'd2)) begin
               st_in = vna_pkg::ST_DONE;
            end
         end
         vna_pkg::ST_DONE: begin
            if (!rsp_vld_ff) begin
               st_in = vna_pkg::ST_IDLE;
            end
         end
         default: st_in = vna_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[cur_ff.vertex_index] <= cur_ff.pos;
      end
      pos_rd_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      acc_rd_ff <= acc_mem[acc_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vna_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         vna_pkg::ST_IDLE: begin
            cur_ff <= cmd_data;
         end
         vna_pkg::ST_RD_B: pa_ff <= pos_rd_ff;
         vna_pkg::ST_RD_C: pb_ff <= pos_rd_ff;
         vna_pkg::ST_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e1_ff[k] <= EW'($signed(pb_ff[(2-k)*PW +: PW]))
                           - EW'($signed(pa_ff[(2-k)*PW +: PW]));
               e2_ff[k] <= EW'($signed(pos_rd_ff[(2-k)*PW +: PW]))
                           - EW'($signed(pa_ff[(2-k)*PW +: PW]));
            end
            cross_cnt_ff <= 2'd0;
         end
         vna_pkg::ST_CROSS: begin
            n_ff[cross_cnt_ff] <= cross_val;
            cross_cnt_ff <= cross_cnt_ff + 2'd1;
            corner_ff <= 2'd0;
         end
         vna_pkg::ST_ACC_WR: corner_ff <= corner_ff + 2'd1;
         vna_pkg::ST_NRM_CAP: begin
            vec_ff[0] <= acc_rd_ff[3*AW-1:2*AW];
            vec_ff[1] <= acc_rd_ff[2*AW-1:AW];
            vec_ff[2] <= acc_rd_ff[AW-1:0];
            comp_ff <= 2'd0;
            part_ff <= 2'd0;
            sum_ff <= '0;
            prod_vld_ff <= 1'b0;
         end
         vna_pkg::ST_SQUARE: begin
            prod_ff <= sq_op1 * sq_op2;
            psh_ff <= part_ff;
            prod_vld_ff <= 1'b1;
            if (prod_vld_ff) begin
               sum_ff <= sum_ff + sum_add;
            end
            if (part_ff == 2'd2) begin
               part_ff <= 2'd0;
               comp_ff <= comp_ff + 2'd1;
            end else begin
               part_ff <= part_ff + 2'd1;
            end
         end
         vna_pkg::ST_SQ_DRAIN: begin
            sum_ff <= sum_ff + sum_add;
            rem_ff <= '0;
            root_ff <= '0;
            step_ff <= '0;
         end
         vna_pkg::ST_SQRT: begin
            sum_ff <= sum_ff << 2;
            if (sq_ge) begin
               rem_ff <= RW'(rem_sh - trial);
               root_ff <= {root_ff[AW-2:0], 1'b1};
            end else begin
               rem_ff <= RW'(rem_sh);
               root_ff <= {root_ff[AW-2:0], 1'b0};
            end
            step_ff <= step_ff + 6'd1;
            comp_ff <= 2'd0;
            bit_ff <= 4'd0;
            r_ff <= RW'(mag(vec_ff[0]));
         end
         vna_pkg::ST_DIV: begin
            zero_ff <= (root_ff == '0);
            q_ff <= q_full[vna_pkg::NRM_W-2:0];
            bit_ff <= bit_ff + 4'd1;
            if (bit_ff == 4'd15) begin
               res_ff[comp_ff] <= q_signed;
            end
            if (bit_ff == 4'd15 && comp_ff != 2'd2) begin
               comp_ff <= comp_ff + 2'd1;
               r_ff <= RW'(mag(vec_ff[comp_ff + 2'd1]));
            end else begin
               r_ff <= RW'({div_diff, 1'b0});
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (st_ff == vna_pkg::ST_DONE && !rsp_vld_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == vna_pkg::ST_DONE && !rsp_vld_ff) begin
         rsp_ff.read_index <= cur_ff.vertex_index;
         rsp_ff.zero_length <= zero_ff;
         rsp_ff.normal_x <= zero_ff ? '0 : res_ff[0];
         rsp_ff.normal_y <= zero_ff ? '0 : res_ff[1];
         rsp_ff.normal_z <= zero_ff ? '0 : res_ff[2];
      end
   end

   assign rsp_empty = !rsp_vld_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == vna_pkg::ST_DIV && root_ff != '0) |-> (r_ff < {root_ff, 1'b0}))
      else $error("division remainder out of range");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (st_ff == vna_pkg::ST_IDLE && !cmd_vld) |=> (st_ff == vna_pkg::ST_IDLE))
      else $error("sequencer left idle without a command");
   a_zero_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.zero_length) |->
      (rsp_ff.normal_x == '0 && rsp_ff.normal_y == '0 && rsp_ff.normal_z == '0))
      else $error("zero-length result carries a nonzero normal");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(st_ff) == vna_pkg::ST_DONE))
      else $error("result raised outside completion");
`endif

endmodule
`default_nettype wire

@@ hdl/vertex_normal_accumulate_core.sv @@
// Top level of the area-weighted vertex normal accumulator.
//
//   channel  ports                            beat taken when
//   request  req_push, req_full, req_data     req_push && !req_full
//   result   rsp_empty, rsp_pop, rsp_data     rsp_pop && !rsp_empty
//
// Triangle add: three position reads through one memory port, three cross
// product terms, then a read-modify-write of each corner's accumulator.
// Normal read: the one-bit-per-cycle square root (48 steps), then divisions
// (16 steps per axis), cut short for a zero normal. Reset is synchronous; the
// vertex memories are not cleared. A four-beat command queue lets requests
// arrive while the sequencer is busy, and the result register lets work
// continue while a result waits to be popped.
`default_nettype none
module vertex_normal_accumulate_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire vna_pkg::req_type req_data,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output vna_pkg::rsp_type rsp_data
);

   logic cmd_vld;
   logic cmd_take;
   vna_pkg::cmd_type cmd_data;

   vna_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .cmd_vld(cmd_vld),
      .cmd_take(cmd_take),
      .cmd_data(cmd_data)
   );

   vna_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_vld(cmd_vld),
      .cmd_take(cmd_take),
      .cmd_data(cmd_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire
